// ===== sv/gwd_pkg.sv =====
// Shared constants and types for the Gaussian Wasserstein distance block.
`timescale 1ns / 1ps
`default_nettype none

package gwd_pkg;

  // Field widths of the two channels
  localparam int unsigned MEAN_W = 32;
  localparam int unsigned LV_W   = 21;
  localparam int unsigned DIST_W = 32;

  // Datapath word and half word
  localparam int unsigned WORD_W = 64;
  localparam int unsigned HALF_W = 32;

  // Default fractional bits of means, log-spreads, sum and distance
  localparam int unsigned FRAC_BITS_DEF = 16;

  // exp(s/2) = exp(|s|/32)^16: series terms, squarings, argument scale
  localparam int unsigned TAYLOR_TERMS   = 12;
  localparam int unsigned SQUARINGS      = 4;
  localparam int unsigned EXP_SCALE_LOG2 = 5;
  localparam int unsigned CLAMP_INT      = 16;

  // Launch control of the shared multiplier
  typedef struct packed {
    logic start;
    logic half;   // 32 steps, product comes out shifted left by HALF_W
  } gwd_mul_ctl_t;

endpackage

`default_nettype wire

// ===== sv/gwd_if.sv =====
// Valid/ready channel interfaces for the item input and the result output.
`timescale 1ns / 1ps
`default_nettype none

interface gwd_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [gwd_pkg::MEAN_W-1:0]   mean_a;
  logic signed [gwd_pkg::LV_W-1:0]     log_var_a;
  logic signed [gwd_pkg::MEAN_W-1:0]   mean_b;
  logic signed [gwd_pkg::LV_W-1:0]     log_var_b;
  logic                                last;

  modport source (output valid, output mean_a, output log_var_a, output mean_b,
                  output log_var_b, output last, input ready);
  modport sink   (input valid, input mean_a, input log_var_a, input mean_b,
                  input log_var_b, input last, output ready);
endinterface

interface gwd_out_if;
  logic                          valid;
  logic                          ready;
  logic [gwd_pkg::DIST_W-1:0]    distance;
  logic                          saturated;

  modport source (output valid, output distance, output saturated, input ready);
  modport sink   (input valid, input distance, input saturated, output ready);
endinterface

`default_nettype wire

// ===== sv/gaussian_wasserstein_distance.sv =====
// Top level: sequencer, accumulator and output register of the distance block.
//
//   channel  dir  payload                                           transaction
//   in_i     in   mean_a, log_var_a, mean_b, log_var_b, last         one dimension
//   out_o    out  distance, saturated                                one distance
//
// An item runs 34 bit-serial multiplies (64 or 32 steps each) and 24 to 26
// divides (32 steps each, 26 when both log-spreads are negative) on one shared
// multiplier and one shared divider.
// An item marked last adds the bit-serial square root (skipped on a saturated sum) and the output load.
// Reset clears the running sum, the saturation flag and the output valid.
// A waiting result does not block the next item; a second result waits for it.
`timescale 1ns / 1ps
`default_nettype none

module gaussian_wasserstein_distance #(
  parameter int unsigned FRAC_BITS = gwd_pkg::FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gwd_in_if.sink      in_i,
  gwd_out_if.source   out_o
);

  localparam int unsigned W      = gwd_pkg::WORD_W;
  localparam int unsigned H      = gwd_pkg::HALF_W;
  localparam int unsigned MEAN_W = gwd_pkg::MEAN_W;
  localparam int unsigned LV_W   = gwd_pkg::LV_W;
  localparam int unsigned DIST_W = gwd_pkg::DIST_W;
  localparam int unsigned K_W    = $clog2(gwd_pkg::TAYLOR_TERMS + 1);
  localparam int unsigned SQ_W   = $clog2(gwd_pkg::SQUARINGS);
  // |s| in Q.FRAC_BITS to |s|/32 in Q32
  localparam int unsigned Y_SH   = H - gwd_pkg::EXP_SCALE_LOG2 - FRAC_BITS;

  localparam logic [W-1:0]    ONE_Q32 = W'(1) << H;
  localparam logic [W-1:0]    LV_LIM  = W'(gwd_pkg::CLAMP_INT) << FRAC_BITS;
  localparam logic [W-1:0]    SUM_BIG = {W{1'b1}} >> FRAC_BITS;
  localparam logic [K_W-1:0]  K_LAST  = K_W'(gwd_pkg::TAYLOR_TERMS);
  localparam logic [SQ_W-1:0] SQ_LAST = SQ_W'(gwd_pkg::SQUARINGS - 1);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_MEAN   = 11'b00000000010,
    S_TMUL   = 11'b00000000100,
    S_TDIV   = 11'b00000001000,
    S_SQR    = 11'b00000010000,
    S_RECIP  = 11'b00000100000,
    S_SIDE   = 11'b00001000000,
    S_SPREAD = 11'b00010000000,
    S_FIN    = 11'b00100000000,
    S_SQRT   = 11'b01000000000,
    S_OUT    = 11'b10000000000
  } state_e;

  state_e              state_q, state_d;
  logic                launch_q, launch_d;
  logic [W-1:0]        sum_q, sum_d;
  logic                sat_seen_q, sat_seen_d;
  logic                side_q, side_d;
  logic [K_W-1:0]      k_q, k_d;
  logic [SQ_W-1:0]     sq_q, sq_d;
  logic                out_valid_q, out_valid_d;

  logic [MEAN_W:0]     adm_q, adm_d;
  logic [LV_W-1:0]     lva_q, lva_d;
  logic [LV_W-1:0]     lvb_q, lvb_d;
  logic                last_q, last_d;
  logic [W-1:0]        term_q, term_d;
  logic [W-1:0]        e_q, e_d;
  logic [W-1:0]        ea_q, ea_d;
  logic [W-1:0]        de_q, de_d;
  logic [DIST_W-1:0]   dist_q, dist_d;
  logic                fin_sat_q, fin_sat_d;
  logic [DIST_W-1:0]   out_dist_q, out_dist_d;
  logic                out_sat_q, out_sat_d;

  // datapath
  logic [MEAN_W:0]     dm;
  logic [LV_W-1:0]     lv_sel;
  logic [LV_W:0]       lv_ext;
  logic [LV_W:0]       lv_abs;
  logic [W-1:0]        mag;
  logic [W-1:0]        y_arg;
  logic                neg;
  logic [W-1:0]        addend;
  logic [W:0]          acc_sum;
  logic [W-1:0]        acc_next;
  logic                out_fire;
  logic                out_load;

  // shared units
  gwd_pkg::gwd_mul_ctl_t mul_ctl;
  logic [W-1:0]        mul_a, mul_b;
  logic                mul_done;
  logic [2*W-1:0]      mul_prod;
  logic                div_start;
  logic [W-1:0]        div_n, div_d;
  logic                div_done;
  logic [H-1:0]        div_q;
  logic                sqrt_start;
  logic                sqrt_done;
  logic [H-1:0]        sqrt_root;

  gwd_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mul_ctl),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  gwd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .n_i     (div_n),
    .d_i     (div_d),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  gwd_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .v_i     (sum_q << FRAC_BITS),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  // Clamped argument of the exponential for the side in work
  always_comb begin
    lv_sel = side_q ? lvb_q : lva_q;
    lv_ext = {lv_sel[LV_W-1], lv_sel};
    lv_abs = lv_ext[LV_W] ? (~lv_ext + 1'b1) : lv_ext;
    mag    = (W'(lv_abs) > LV_LIM) ? LV_LIM : W'(lv_abs);
    y_arg  = mag << Y_SH;
    neg    = lv_sel[LV_W-1];
  end

  // Unit operands and launches
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    mul_ctl.half  = 1'b0;
    mul_ctl.start = 1'b0;
    div_n = '0;
    div_d = '0;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    case (state_q)
      S_MEAN: begin
        mul_a = W'(adm_q);
        mul_b = W'(adm_q);
        mul_ctl.start = launch_q;
      end
      S_TMUL: begin
        mul_a = term_q;
        mul_b = y_arg;
        mul_ctl.half  = 1'b1;
        mul_ctl.start = launch_q;
      end
      S_SQR: begin
        mul_a = e_q;
        mul_b = e_q;
        mul_ctl.start = launch_q;
      end
      S_SPREAD: begin
        mul_a = de_q;
        mul_b = de_q;
        mul_ctl.start = launch_q;
      end
      S_TDIV: begin
        div_n = mul_prod[W +: W];
        div_d = W'(k_q);
        div_start = launch_q;
      end
      S_RECIP: begin
        div_n = {W{1'b1}};
        div_d = e_q;
        div_start = launch_q;
      end
      S_SQRT: begin
        sqrt_start = launch_q;
      end
      default: begin
      end
    endcase
  end

  // Saturating accumulate of the mean or the spread term
  always_comb begin
    addend   = (state_q == S_SPREAD) ? mul_prod[(W - FRAC_BITS) +: W]
                                     : mul_prod[FRAC_BITS +: W];
    acc_sum  = {1'b0, sum_q} + {1'b0, addend};
    acc_next = acc_sum[W] ? {W{1'b1}} : acc_sum[W-1:0];
  end

  assign out_fire = out_valid_q && out_o.ready;
  assign out_load = (state_q == S_OUT) && (!out_valid_q || out_fire);

  always_comb begin
    dm = {in_i.mean_a[MEAN_W-1], in_i.mean_a} - {in_i.mean_b[MEAN_W-1], in_i.mean_b};

    state_d     = state_q;
    launch_d    = 1'b0;
    sum_d       = sum_q;
    sat_seen_d  = sat_seen_q;
    side_d      = side_q;
    k_d         = k_q;
    sq_d        = sq_q;
    out_valid_d = out_valid_q && !out_fire;
    adm_d       = adm_q;
    lva_d       = lva_q;
    lvb_d       = lvb_q;
    last_d      = last_q;
    term_d      = term_q;
    e_d         = e_q;
    ea_d        = ea_q;
    de_d        = de_q;
    dist_d      = dist_q;
    fin_sat_d   = fin_sat_q;
    out_dist_d  = out_dist_q;
    out_sat_d   = out_sat_q;

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          adm_d    = dm[MEAN_W] ? (~dm + 1'b1) : dm;
          lva_d    = in_i.log_var_a;
          lvb_d    = in_i.log_var_b;
          last_d   = in_i.last;
          state_d  = S_MEAN;
          launch_d = 1'b1;
        end
      end
      S_MEAN: begin
        if (mul_done) begin
          sum_d = acc_next;
          if (acc_sum[W]) begin
            sat_seen_d = 1'b1;
          end
          side_d   = 1'b0;
          term_d   = ONE_Q32;
          e_d      = ONE_Q32;
          k_d      = K_W'(1);
          state_d  = S_TMUL;
          launch_d = 1'b1;
        end
      end
      S_TMUL: begin
        if (mul_done) begin
          state_d  = S_TDIV;
          launch_d = 1'b1;
        end
      end
      S_TDIV: begin
        if (div_done) begin
          term_d   = W'(div_q);
          e_d      = e_q + W'(div_q);
          launch_d = 1'b1;
          if (k_q == K_LAST) begin
            sq_d    = '0;
            state_d = S_SQR;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = S_TMUL;
          end
        end
      end
      S_SQR: begin
        if (mul_done) begin
          e_d = mul_prod[H +: W];
          if (sq_q == SQ_LAST) begin
            if (neg) begin
              state_d  = S_RECIP;
              launch_d = 1'b1;
            end else begin
              state_d = S_SIDE;
            end
          end else begin
            sq_d     = sq_q + 1'b1;
            launch_d = 1'b1;
          end
        end
      end
      S_RECIP: begin
        if (div_done) begin
          e_d     = W'(div_q);
          state_d = S_SIDE;
        end
      end
      S_SIDE: begin
        launch_d = 1'b1;
        if (!side_q) begin
          // hold side A, restart the series for side B
          ea_d    = e_q;
          side_d  = 1'b1;
          term_d  = ONE_Q32;
          e_d     = ONE_Q32;
          k_d     = K_W'(1);
          state_d = S_TMUL;
        end else begin
          de_d    = (ea_q > e_q) ? (ea_q - e_q) : (e_q - ea_q);
          state_d = S_SPREAD;
        end
      end
      S_SPREAD: begin
        if (mul_done) begin
          sum_d = acc_next;
          if (acc_sum[W]) begin
            sat_seen_d = 1'b1;
          end
          state_d = last_q ? S_FIN : S_IDLE;
        end
      end
      S_FIN: begin
        if (sum_q > SUM_BIG) begin
          dist_d    = {DIST_W{1'b1}};
          fin_sat_d = 1'b1;
          state_d   = S_OUT;
        end else begin
          fin_sat_d = sat_seen_q;
          state_d   = S_SQRT;
          launch_d  = 1'b1;
        end
      end
      S_SQRT: begin
        if (sqrt_done) begin
          dist_d  = DIST_W'(sqrt_root);
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          out_dist_d  = dist_q;
          out_sat_d   = fin_sat_q;
          sum_d       = '0;
          sat_seen_d  = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      launch_q    <= 1'b0;
      sum_q       <= '0;
      sat_seen_q  <= 1'b0;
      side_q      <= 1'b0;
      k_q         <= '0;
      sq_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      launch_q    <= launch_d;
      sum_q       <= sum_d;
      sat_seen_q  <= sat_seen_d;
      side_q      <= side_d;
      k_q         <= k_d;
      sq_q        <= sq_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    adm_q      <= adm_d;
    lva_q      <= lva_d;
    lvb_q      <= lvb_d;
    last_q     <= last_d;
    term_q     <= term_d;
    e_q        <= e_d;
    ea_q       <= ea_d;
    de_q       <= de_d;
    dist_q     <= dist_d;
    fin_sat_q  <= fin_sat_d;
    out_dist_q <= out_dist_d;
    out_sat_q  <= out_sat_d;
  end

  assign in_i.ready      = (state_q == S_IDLE);
  assign out_o.valid     = out_valid_q;
  assign out_o.distance  = out_dist_q;
  assign out_o.saturated = out_sat_q;

`ifndef NO_ASSERTIONS
  a_mul_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == S_MEAN || state_q == S_TMUL ||
                  state_q == S_SQR || state_q == S_SPREAD))
    else $error("multiplier finished outside a multiply step");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_TDIV || state_q == S_RECIP))
    else $error("divider finished outside a divide step");

  a_div_quotient_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (div_n[W-1:H] < div_d))
    else $error("divide launched with a quotient wider than 32 bits");

  a_clear_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (sum_q == '0 && !sat_seen_q))
    else $error("running sum not cleared after a result");
`endif

endmodule

`default_nettype wire

// ===== sv/gwd_mul.sv =====
// Shift-add multiplier: one multiplier bit per cycle, 64 or 32 steps.
`timescale 1ns / 1ps
`default_nettype none

module gwd_mul (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  gwd_pkg::gwd_mul_ctl_t            ctl_i,
  input  logic [gwd_pkg::WORD_W-1:0]       a_i,
  input  logic [gwd_pkg::WORD_W-1:0]       b_i,
  output logic                             done_o,
  output logic [2*gwd_pkg::WORD_W-1:0]     prod_o
);

  localparam int unsigned W     = gwd_pkg::WORD_W;
  localparam int unsigned H     = gwd_pkg::HALF_W;
  localparam int unsigned CNT_W = $clog2(W);

  logic [W-1:0]     a_q;
  logic [W-1:0]     b_q, b_d;
  logic [2*W-1:0]   acc_q, acc_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [W-1:0]     addend;
  logic [W:0]       sum;

  always_comb begin
    addend = b_q[0] ? a_q : {W{1'b0}};
    sum    = {1'b0, acc_q[2*W-1:W]} + {1'b0, addend};
    acc_d  = acc_q;
    b_d    = b_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (ctl_i.start) begin
      acc_d  = '0;
      b_d    = b_i;
      cnt_d  = ctl_i.half ? CNT_W'(H - 1) : CNT_W'(W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // add at the top, shift the whole accumulator right
      acc_d = {sum, acc_q[W-1:1]};
      b_d   = b_q >> 1;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      a_q <= a_i;
    end
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

`default_nettype wire

// ===== sv/gwd_div.sv =====
// Restoring divider: one quotient bit per cycle, 32-bit quotient.
`timescale 1ns / 1ps
`default_nettype none

module gwd_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [gwd_pkg::WORD_W-1:0]   n_i,
  input  logic [gwd_pkg::WORD_W-1:0]   d_i,
  output logic                         done_o,
  output logic [gwd_pkg::HALF_W-1:0]   q_o
);

  localparam int unsigned W     = gwd_pkg::WORD_W;
  localparam int unsigned H     = gwd_pkg::HALF_W;
  localparam int unsigned CNT_W = $clog2(H);

  logic [W-1:0]     rem_q, rem_d;
  logic [H-1:0]     n_q, n_d;
  logic [W-1:0]     d_q;
  logic [H-1:0]     q_q, q_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [W:0]       trial;
  logic [W:0]       diff;
  logic             ge;

  always_comb begin
    trial  = {rem_q, n_q[H-1]};
    diff   = trial - {1'b0, d_q};
    ge     = trial >= {1'b0, d_q};
    rem_d  = rem_q;
    n_d    = n_q;
    q_d    = q_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      // upper dividend half is below the divisor, so it seeds the remainder
      rem_d  = n_i[W-1:H];
      n_d    = n_i[H-1:0];
      cnt_d  = CNT_W'(H - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[W-1:0] : trial[W-1:0];
      n_d   = n_q << 1;
      q_d   = {q_q[H-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      d_q <= d_i;
    end
    rem_q <= rem_d;
    n_q   <= n_d;
    q_q   <= q_d;
  end

  assign done_o = done_q;
  assign q_o    = q_q;

endmodule

`default_nettype wire

// ===== sv/gwd_sqrt.sv =====
// Integer square root of a 64-bit word, one root bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module gwd_sqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [gwd_pkg::WORD_W-1:0]   v_i,
  output logic                         done_o,
  output logic [gwd_pkg::HALF_W-1:0]   root_o
);

  localparam int unsigned W     = gwd_pkg::WORD_W;
  localparam int unsigned H     = gwd_pkg::HALF_W;
  localparam int unsigned CNT_W = $clog2(H);

  logic [W-1:0]     v_q, v_d;
  logic [H+1:0]     rem_q, rem_d;
  logic [H-1:0]     root_q, root_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [H+3:0]     rem2;
  logic [H+3:0]     trial;
  logic [H+3:0]     diff;
  logic             ge;

  always_comb begin
    rem2   = {rem_q, v_q[W-1 -: 2]};
    trial  = {2'b00, root_q, 2'b01};
    diff   = rem2 - trial;
    ge     = rem2 >= trial;
    v_d    = v_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      v_d    = v_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CNT_W'(H - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // bring down two radicand bits, try root*4+1
      v_d    = v_q << 2;
      rem_d  = ge ? diff[H+1:0] : rem2[H+1:0];
      root_d = {root_q[H-2:0], ge};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q    <= v_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire
